// ===== hw/rtl/rgb_to_hsv_pixel_unit_macros.svh =====
// Assertion macros for the RGB to HSV pixel unit.
`ifndef RGB_TO_HSV_PIXEL_UNIT_MACROS_SVH
`define RGB_TO_HSV_PIXEL_UNIT_MACROS_SVH

// same-cycle implication
`define RHSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define RHSV_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ===== hw/rtl/rhsv_pkg.sv =====
// Package: types, constants and helpers for the RGB to HSV pixel unit.
`default_nettype none

package rhsv_pkg;

  localparam int CH_W         = 8;
  localparam int Q_W          = 8;
  localparam int NUM_W        = 17;
  localparam int DEN_W        = 9;
  localparam int DIFF_W       = 9;
  localparam int M_W          = 11;
  localparam int DIV_STAGES   = 4;
  localparam int DIV_BPS      = Q_W / DIV_STAGES;
  localparam int FRONT_STAGES = 2;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [CH_W-1:0] CH_MAX    = 8'd255;
  localparam logic [CH_W-1:0] BLACK_HUE = 8'd180;
  localparam logic [CH_W-1:0] WHITE_HUE = 8'd90;
  localparam logic [CH_W-1:0] GRAY_HUE  = 8'd105;
  localparam logic [CH_W-1:0] HUE_MAX   = 8'd180;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rhsv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } rhsv_out_t;

  typedef enum logic [1:0] {
    SEC_RED_MIN,
    SEC_GREEN_MIN,
    SEC_BLUE_MIN
  } rhsv_sector_t;

  typedef struct packed {
    logic [CH_W-1:0] hi;
    logic            gray;
  } rhsv_side_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num_h;
    logic [DEN_W-1:0] den_h;
    logic [NUM_W-1:0] num_s;
    logic [DEN_W-1:0] den_s;
    rhsv_side_t       side;
  } rhsv_fe_t;

  // round(13.005 / (c + 0.0255)) for gray levels 1..254
  function automatic logic [CH_W-1:0] gray_sat(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] s;
    priority if (c == 8'd1)  s = 8'd13;
    else if (c == 8'd2)      s = 8'd6;
    else if (c == 8'd3)      s = 8'd4;
    else if (c <= 8'd5)      s = 8'd3;
    else if (c <= 8'd8)      s = 8'd2;
    else if (c <= 8'd25)     s = 8'd1;
    else                     s = 8'd0;
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_pixel_unit.sv =====
// Top level: RGB to HSV pixel unit, front end, two dividers and output register.
// Takes one pixel request per clock; busy is always low. Each result shows on
// out_data with out_valid high for one cycle, after passing through the
// pipeline: two front stages for max/min and operands, four stages of each
// restoring divider (two quotient bits a stage) and the output register.
// Results leave in request order and cannot be held off.
`default_nettype none

`include "rgb_to_hsv_pixel_unit_macros.svh"

module rgb_to_hsv_pixel_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rhsv_pkg::rhsv_in_t   in_data,
  output logic                 out_valid,
  output rhsv_pkg::rhsv_out_t  out_data
);
  import rhsv_pkg::*;

  rhsv_fe_t        fe;
  logic [Q_W-1:0]  quo_h, quo_s;
  logic            dv_r   [DIV_STAGES];
  rhsv_side_t      side_r [DIV_STAGES];
  logic            out_valid_r, out_valid_nxt;
  rhsv_out_t       out_data_r, out_data_nxt;

  assign busy = 1'b0;

  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .fe_o     (fe)
  );

  rhsv_div u_div_hue (
    .clk   (clk),
    .num_i (fe.num_h),
    .den_i (fe.den_h),
    .quo_o (quo_h)
  );

  rhsv_div u_div_sat (
    .clk   (clk),
    .num_i (fe.num_s),
    .den_i (fe.den_s),
    .quo_o (quo_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) dv_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r[0] <= fe.valid;
      for (int s = 1; s < DIV_STAGES; s++) dv_r[s] <= dv_r[s-1];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= fe.side;
    for (int s = 1; s < DIV_STAGES; s++) side_r[s] <= side_r[s-1];
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    rhsv_side_t sd;
    sd = side_r[DIV_STAGES-1];
    out_valid_nxt = dv_r[DIV_STAGES-1];
    out_data_nxt.brightness = sd.hi;
    if (!sd.gray) begin
      out_data_nxt.hue        = quo_h;
      out_data_nxt.saturation = quo_s;
    end else if (sd.hi == '0) begin
      out_data_nxt.hue        = BLACK_HUE;
      out_data_nxt.saturation = CH_MAX;
    end else if (sd.hi == CH_MAX) begin
      out_data_nxt.hue        = WHITE_HUE;
      out_data_nxt.saturation = '0;
    end else begin
      out_data_nxt.hue        = GRAY_HUE;
      out_data_nxt.saturation = gray_sat(sd.hi);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RHSV_ASSERT_DLY(a_req_to_result, clk, rst_n, start && !busy, LATENCY, out_valid,
    "request produced no result")
  `RHSV_ASSERT_DLY(a_no_phantom, clk, rst_n, !start, LATENCY, !out_valid,
    "result without request")
  `RHSV_ASSERT_NOW(a_hue_range, clk, rst_n, out_valid, out_data.hue <= HUE_MAX,
    "hue out of range")
  `RHSV_ASSERT_NOW(a_black, clk, rst_n, out_valid && out_data.brightness == '0,
    out_data.hue == BLACK_HUE && out_data.saturation == CH_MAX, "black pixel mismatch")

endmodule

`default_nettype wire

// ===== hw/rtl/rhsv_front.sv =====
// Front end: max/min, sector choice and divider operands, two register stages.
`default_nettype none

module rhsv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rhsv_pkg::rhsv_in_t  in_data,
  output rhsv_pkg::rhsv_fe_t  fe_o
);
  import rhsv_pkg::*;

  logic                     a_valid_r, a_valid_nxt;
  logic [CH_W-1:0]          a_hi_r, a_hi_nxt;
  logic [CH_W-1:0]          a_d_r, a_d_nxt;
  rhsv_sector_t             a_sec_r, a_sec_nxt;
  logic signed [DIFF_W-1:0] a_diff_r, a_diff_nxt;

  rhsv_fe_t fe_r, fe_nxt;

  // stage A
  always_comb begin
    logic [CH_W-1:0] lo;
    logic [DIFF_W-1:0] r9, g9, b9;
    r9 = {1'b0, in_data.red};
    g9 = {1'b0, in_data.green};
    b9 = {1'b0, in_data.blue};
    a_hi_nxt = in_data.red;
    lo = in_data.red;
    if (in_data.green > a_hi_nxt) a_hi_nxt = in_data.green;
    if (in_data.blue > a_hi_nxt)  a_hi_nxt = in_data.blue;
    if (in_data.green < lo) lo = in_data.green;
    if (in_data.blue < lo)  lo = in_data.blue;
    a_d_nxt = a_hi_nxt - lo;
    priority if (in_data.red == lo) begin
      a_sec_nxt  = SEC_RED_MIN;
      a_diff_nxt = $signed(g9 - b9);
    end else if (in_data.green == lo) begin
      a_sec_nxt  = SEC_GREEN_MIN;
      a_diff_nxt = $signed(b9 - r9);
    end else begin
      a_sec_nxt  = SEC_BLUE_MIN;
      a_diff_nxt = $signed(r9 - g9);
    end
    a_valid_nxt = in_valid;
  end

  // stage B
  always_comb begin
    logic [M_W-1:0] kd;
    logic signed [M_W:0] m_s;
    logic [M_W-1:0] m;
    logic [NUM_W-1:0] d17;
    d17 = NUM_W'(a_d_r);
    unique case (a_sec_r)
      SEC_RED_MIN:   kd = M_W'(a_d_r) + (M_W'(a_d_r) << 1);
      SEC_GREEN_MIN: kd = M_W'(a_d_r) + (M_W'(a_d_r) << 2);
      SEC_BLUE_MIN:  kd = M_W'(a_d_r);
      default:       kd = '0;
    endcase
    m_s = $signed({1'b0, kd}) - (M_W+1)'(a_diff_r);
    m   = m_s[M_W-1:0];
    fe_nxt.valid     = a_valid_r;
    fe_nxt.side.hi   = a_hi_r;
    fe_nxt.side.gray = (a_d_r == '0);
    if (a_d_r == '0) begin
      fe_nxt.num_h = '0;
      fe_nxt.den_h = DEN_W'(2);
      fe_nxt.num_s = '0;
      fe_nxt.den_s = DEN_W'(2);
    end else begin
      fe_nxt.num_h = (NUM_W'(m) << 6) - (NUM_W'(m) << 2) + d17;
      fe_nxt.den_h = {a_d_r, 1'b0};
      fe_nxt.num_s = (d17 << 9) - (d17 << 1) + NUM_W'(a_hi_r);
      fe_nxt.den_s = {a_hi_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      fe_r.valid <= 1'b0;
    end else begin
      a_valid_r  <= a_valid_nxt;
      fe_r.valid <= fe_nxt.valid;
    end
    a_hi_r     <= a_hi_nxt;
    a_d_r      <= a_d_nxt;
    a_sec_r    <= a_sec_nxt;
    a_diff_r   <= a_diff_nxt;
    fe_r.num_h <= fe_nxt.num_h;
    fe_r.den_h <= fe_nxt.den_h;
    fe_r.num_s <= fe_nxt.num_s;
    fe_r.den_s <= fe_nxt.den_s;
    fe_r.side  <= fe_nxt.side;
  end

  assign fe_o = fe_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rhsv_div.sv =====
// Pipelined restoring divider, 8-bit quotient, two quotient bits per stage.
`default_nettype none

module rhsv_div (
  input  logic                         clk,
  input  logic [rhsv_pkg::NUM_W-1:0]   num_i,
  input  logic [rhsv_pkg::DEN_W-1:0]   den_i,
  output logic [rhsv_pkg::Q_W-1:0]     quo_o
);
  import rhsv_pkg::*;

  logic [NUM_W-1:0] rem_r   [DIV_STAGES-1];
  logic [DEN_W-1:0] den_r   [DIV_STAGES-1];
  logic [Q_W-1:0]   quo_r   [DIV_STAGES];
  logic [NUM_W-1:0] rem_in  [DIV_STAGES];
  logic [DEN_W-1:0] den_in  [DIV_STAGES];
  logic [Q_W-1:0]   quo_in  [DIV_STAGES];
  logic [NUM_W-1:0] rem_nxt [DIV_STAGES-1];
  logic [Q_W-1:0]   quo_nxt [DIV_STAGES];

  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s] = rem_r[s-1];
      den_in[s] = den_r[s-1];
      quo_in[s] = quo_r[s-1];
    end
  end

  always_comb begin
    logic [NUM_W-1:0] rem_v;
    logic [NUM_W-1:0] dsh;
    logic [Q_W-1:0]   q_v;
    for (int s = 0; s < DIV_STAGES-1; s++) rem_nxt[s] = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_v = rem_in[s];
      q_v   = quo_in[s];
      for (int j = 0; j < DIV_BPS; j++) begin
        dsh = NUM_W'(den_in[s]) << (Q_W - 1 - s*DIV_BPS - j);
        if (rem_v >= dsh) begin
          rem_v = rem_v - dsh;
          q_v[Q_W - 1 - s*DIV_BPS - j] = 1'b1;
        end
      end
      quo_nxt[s] = q_v;
      if (s < DIV_STAGES-1) rem_nxt[s] = rem_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) quo_r[s] <= quo_nxt[s];
    for (int s = 0; s < DIV_STAGES-1; s++) begin
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_in[s];
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire
